[rtl/sfr_pkg.sv]
// Package for the serial frame receiver.
// Holds the phase and error codes, field widths and the result struct.
// No dependencies.
package sfr_pkg;

  localparam int unsigned BufferDepth = 1024;
  localparam int unsigned HeaderLen   = 5;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN0 = 3'd1;
  localparam logic [2:0] PH_LEN1 = 3'd2;
  localparam logic [2:0] PH_HEAD = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;
  localparam logic [2:0] PH_END  = 3'd6;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_CHECKSUM = 2'd2;
  localparam logic [1:0] ERR_ENDBYTE  = 2'd3;

  localparam logic [1:0] CFG_START_BYTE = 2'd0;
  localparam logic [1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

  localparam logic [10:0] MAX_LENGTH_RESET = 11'd1024;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [10:0] max_length;
  } sfr_cfg_t;

  typedef struct packed {
    logic        byte_valid;
    logic [9:0]  byte_index;
    logic [7:0]  byte_value;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [10:0] frame_length;
  } sfr_result_t;

endpackage

[rtl/sfr_cfg_regs.sv]
// Configuration register bank of the serial frame receiver.
// Depends on sfr_pkg for register indexes and the configuration struct.
module sfr_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_addr,
  input  logic [10:0]      cfg_data,
  output sfr_pkg::sfr_cfg_t cfg
);
  import sfr_pkg::*;

  sfr_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= 8'd0;
      cfg_r.end_byte   <= 8'd0;
      cfg_r.max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_START_BYTE: cfg_r.start_byte <= cfg_data[7:0];
        CFG_END_BYTE:   cfg_r.end_byte   <= cfg_data[7:0];
        CFG_MAX_LENGTH: cfg_r.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/sfr_deframer.sv]
// Frame parsing state machine of the serial frame receiver.
// Computes one result per registered byte and updates the frame state.
// Depends on sfr_pkg.
module sfr_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic [7:0]           rx_byte,
  input  logic                 gap_timeout,
  input  sfr_pkg::sfr_cfg_t    cfg,
  output sfr_pkg::sfr_result_t res
);
  import sfr_pkg::*;

  logic [2:0]  phase_r, phase_nxt, phase_cur;
  logic [15:0] length_r, length_nxt;
  logic [10:0] count_r, count_nxt, count_inc;
  logic [7:0]  sum_r, sum_nxt;
  logic [1:0]  err_r, err_nxt, err_end;
  logic [15:0] len_full;

  assign phase_cur = gap_timeout ? PH_HUNT : phase_r;
  assign count_inc = count_r + 11'd1;
  assign len_full  = {length_r[15:8], rx_byte};
  assign err_end   = (rx_byte != cfg.end_byte) ? ERR_ENDBYTE : err_r;

  always_comb begin
    phase_nxt  = phase_cur;
    length_nxt = length_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    err_nxt    = err_r;
    res        = '0;
    case (phase_cur)
      PH_HUNT: begin
        if (rx_byte == cfg.start_byte) begin
          count_nxt = 11'd0;
          phase_nxt = PH_LEN0;
        end
      end
      PH_LEN0: begin
        length_nxt = {rx_byte, 8'd0};
        sum_nxt    = rx_byte;
        phase_nxt  = PH_LEN1;
      end
      PH_LEN1: begin
        length_nxt = len_full;
        if (len_full < 16'(HeaderLen) || len_full > {5'd0, cfg.max_length}) begin
          err_nxt   = ERR_LENGTH;
          phase_nxt = PH_HUNT;
        end else begin
          sum_nxt   = sum_r + rx_byte;
          phase_nxt = PH_HEAD;
        end
      end
      PH_HEAD: begin
        res.byte_valid = 1'b1;
        res.byte_index = count_r[9:0];
        res.byte_value = rx_byte;
        count_nxt      = count_inc;
        sum_nxt        = sum_r + rx_byte;
        if (count_inc >= 11'(HeaderLen)) begin
          phase_nxt = (length_r <= 16'(HeaderLen)) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (count_r < cfg.max_length && count_r < 11'(BufferDepth)) begin
          res.byte_valid = 1'b1;
          res.byte_index = count_r[9:0];
          res.byte_value = rx_byte;
        end
        count_nxt = count_inc;
        sum_nxt   = sum_r + rx_byte;
        if (length_r <= {5'd0, count_inc}) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        if (sum_r == rx_byte) begin
          phase_nxt = PH_END;
        end else begin
          err_nxt   = ERR_CHECKSUM;
          phase_nxt = PH_HUNT;
        end
      end
      PH_END: begin
        res.frame_done   = 1'b1;
        res.frame_status = err_end;
        res.frame_length = length_r[10:0];
        err_nxt          = ERR_NONE;
        phase_nxt        = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      length_r <= 16'd0;
      count_r  <= 11'd0;
      sum_r    <= 8'd0;
      err_r    <= ERR_NONE;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      err_r    <= err_nxt;
    end
  end

  a_err_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.frame_done |=> err_r == ERR_NONE)
    else $error("latched error not cleared after frame completion");

  a_no_unused_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 3'd7)
    else $error("state machine reached an unused phase");

  a_byte_or_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.byte_valid && res.frame_done))
    else $error("stored byte and frame completion in one result");

  a_gap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    advance && gap_timeout |-> !res.byte_valid && !res.frame_done)
    else $error("result produced on a gap timeout");

endmodule

[rtl/serial_frame_receiver.sv]
// Serial frame receiver: one byte per transfer. Each result transfer follows its
// input transfer through the input register, then the result register.
// Throughput is one byte per cycle; the stages advance together when the
// result register is empty or being drained.
// Synchronous active-low reset clears the state machine, latched error,
// configuration and both stage valid flags; the block is ready right after.
module serial_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] gap_timeout
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] byte_index, [17:10] byte_value,
                                  // [19:18] frame_status, [30:20] frame_length
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_data
);
  import sfr_pkg::*;

  sfr_cfg_t    cfg;
  sfr_result_t res;
  sfr_result_t out_r;
  logic        in_vld_r, out_vld_r;
  logic [7:0]  rx_byte_r;
  logic        gap_r;
  logic        advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfr_deframer u_deframer (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .rx_byte     (rx_byte_r),
    .gap_timeout (gap_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rx_byte_r <= in_tdata;
      gap_r     <= in_tuser;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_r.frame_length, out_r.frame_status,
                       out_r.byte_value, out_r.byte_index};
  assign out_tuser  = {out_r.frame_done, out_r.byte_valid};

endmodule

[dv/serial_frame_receiver_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for serial_frame_receiver: directed and random byte streams,
// with a cycle-free deframer prediction checked against every result transfer.
// Depends on sfr_pkg and the serial_frame_receiver RTL only.
module serial_frame_receiver_test;
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_BAD_LENGTH, FRAME_GAP
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [10:0] cfg_data = '0;

  // Register copies and deframer state as the predictor sees them.
  logic [7:0]  cur_start_byte;
  logic [7:0]  cur_end_byte;
  logic [10:0] cur_max_length;
  logic [2:0]  rx_phase;
  logic [15:0] length_field;
  logic [10:0] byte_count;
  logic [7:0]  running_sum;
  logic [1:0]  latched_error;

  sfr_result_t expected_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int frames_completed = 0;
  int reg_writes = 0;
  int mismatch_count = 0;

  serial_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_deframer();
    cur_start_byte = 8'h00;
    cur_end_byte   = 8'h00;
    cur_max_length = MAX_LENGTH_RESET;
    rx_phase       = PH_HUNT;
    length_field   = '0;
    byte_count     = '0;
    running_sum    = '0;
    latched_error  = ERR_NONE;
  endfunction

  function automatic sfr_result_t deframe_byte(input logic [7:0] b, input logic gap);
    sfr_result_t r;
    r = '0;
    if (gap) rx_phase = PH_HUNT;
    case (rx_phase)
      PH_HUNT: begin
        if (b == cur_start_byte) begin
          byte_count = '0;
          rx_phase = PH_LEN0;
        end
      end
      PH_LEN0: begin
        length_field = {b, 8'h00};
        running_sum = b;
        rx_phase = PH_LEN1;
      end
      PH_LEN1: begin
        length_field = length_field | {8'h00, b};
        if (length_field < HeaderLen || length_field > cur_max_length) begin
          latched_error = ERR_LENGTH;
          rx_phase = PH_HUNT;
        end else begin
          running_sum = running_sum + b;
          rx_phase = PH_HEAD;
        end
      end
      PH_HEAD: begin
        r.byte_valid = 1'b1;
        r.byte_index = byte_count[9:0];
        r.byte_value = b;
        byte_count = byte_count + 1'b1;
        running_sum = running_sum + b;
        if (byte_count >= HeaderLen) begin
          rx_phase = (length_field <= HeaderLen) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (byte_count < cur_max_length && byte_count < BufferDepth) begin
          r.byte_valid = 1'b1;
          r.byte_index = byte_count[9:0];
          r.byte_value = b;
        end
        byte_count = byte_count + 1'b1;
        running_sum = running_sum + b;
        if (length_field <= byte_count) rx_phase = PH_SUM;
      end
      PH_SUM: begin
        if (running_sum == b) begin
          rx_phase = PH_END;
        end else begin
          latched_error = ERR_CHECKSUM;
          rx_phase = PH_HUNT;
        end
      end
      PH_END: begin
        if (b != cur_end_byte) latched_error = ERR_ENDBYTE;
        r.frame_done = 1'b1;
        r.frame_status = latched_error;
        r.frame_length = length_field[10:0];
        latched_error = ERR_NONE;
        rx_phase = PH_HUNT;
        frames_completed++;
      end
      default: begin
        rx_phase = PH_HUNT;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 40) begin
      $display("MISMATCH %s: got %0d, expected %0d, at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    sfr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected", out_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser[0] !== want.byte_valid)
          report_mismatch("byte_valid", out_tuser[0], want.byte_valid);
        if (out_tdata[9:0] !== want.byte_index)
          report_mismatch("byte_index", out_tdata[9:0], want.byte_index);
        if (out_tdata[17:10] !== want.byte_value)
          report_mismatch("byte_value", out_tdata[17:10], want.byte_value);
        if (out_tuser[1] !== want.frame_done)
          report_mismatch("frame_done", out_tuser[1], want.frame_done);
        if (out_tdata[19:18] !== want.frame_status)
          report_mismatch("frame_status", out_tdata[19:18], want.frame_status);
        if (out_tdata[30:20] !== want.frame_length)
          report_mismatch("frame_length", out_tdata[30:20], want.frame_length);
      end
      results_checked++;
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic gap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= gap;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(deframe_byte(b, gap));
    bytes_sent++;
  endtask

  // Lets every expected result arrive, then waits for the pipeline to empty.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [10:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (addr)
      CFG_START_BYTE: cur_start_byte = value[7:0];
      CFG_END_BYTE:   cur_end_byte = value[7:0];
      CFG_MAX_LENGTH: cur_max_length = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_frame(input logic [15:0] len, input frame_kind_t kind,
                            input logic gap_on_start);
    logic [7:0] b;
    logic [7:0] sum;
    int cut;
    sum = len[15:8] + len[7:0];
    cut = (kind == FRAME_GAP) ? $urandom_range(int'(len) - 1, 0) : -1;
    send_byte(cur_start_byte, gap_on_start);
    send_byte(len[15:8], 1'b0);
    send_byte(len[7:0], 1'b0);
    if (kind == FRAME_BAD_LENGTH) return;
    for (int i = 0; i < int'(len); i++) begin
      if (i == cut) begin
        do b = 8'($urandom); while (b == cur_start_byte);
        send_byte(b, 1'b1);
        return;
      end
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b, 1'b0);
    end
    if (kind == FRAME_BAD_SUM) begin
      send_byte(sum ^ 8'($urandom_range(255, 1)), 1'b0);
      return;
    end
    send_byte(sum, 1'b0);
    send_byte((kind == FRAME_BAD_END) ? cur_end_byte ^ 8'($urandom_range(255, 1))
                                      : cur_end_byte, 1'b0);
  endtask

  task automatic send_noise(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      do b = 8'($urandom); while (b == cur_start_byte);
      send_byte(b, ($urandom_range(9) == 0));
    end
  endtask

  task automatic test_reset_registers();
    send_frame(16'd5, FRAME_GOOD, 1'b0);
  endtask

  task automatic test_length_errors();
    write_reg(CFG_START_BYTE, 11'h0FF);
    write_reg(CFG_END_BYTE, 11'h07E);
    write_reg(CFG_MAX_LENGTH, 11'd5);
    send_frame(16'h0000, FRAME_BAD_LENGTH, 1'b0);
    send_frame(16'hFFFF, FRAME_BAD_LENGTH, 1'b0);
    send_frame(16'd6, FRAME_BAD_LENGTH, 1'b0);
  endtask

  // The checksum error replaces the pending length error; the frame after the
  // timeout restart must report it.
  task automatic test_checksum_and_gap();
    send_frame(16'd5, FRAME_BAD_SUM, 1'b0);
    send_byte(cur_start_byte, 1'b0);
    send_byte(8'h00, 1'b0);
    send_frame(16'd5, FRAME_GOOD, 1'b1);
  endtask

  // Lowering max_length in the middle of a payload stops storage, not counting.
  task automatic test_storage_bound();
    logic [7:0] b;
    logic [7:0] sum;
    write_reg(CFG_MAX_LENGTH, 11'd8);
    send_byte(cur_start_byte, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h08, 1'b0);
    sum = 8'h08;
    for (int i = 0; i < 6; i++) begin
      if (i == 5) write_reg(CFG_MAX_LENGTH, 11'd6);
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b, 1'b0);
    end
    for (int i = 0; i < 2; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b, 1'b0);
    end
    send_byte(sum, 1'b0);
    send_byte(cur_end_byte, 1'b0);
  endtask

  task automatic test_random_traffic(input int item_count);
    int stop_at;
    int pick;
    int lim;
    logic [15:0] len;
    frame_kind_t kind;
    stop_at = bytes_sent + item_count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(14) == 0) begin
        pick = $urandom_range(3);
        if (pick == 0) write_reg(CFG_START_BYTE, 11'($urandom_range(255)));
        else if (pick == 1) write_reg(CFG_END_BYTE, 11'($urandom_range(255)));
        else if (pick == 2) write_reg(CFG_MAX_LENGTH, 11'($urandom_range(64, 5)));
        else write_reg(CFG_MAX_LENGTH, ($urandom_range(1) == 0) ? 11'd5 : 11'd1024);
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_noise($urandom_range(4, 1));
      end else begin
        if (pick < 16) kind = FRAME_BAD_LENGTH;
        else if (pick < 26) kind = FRAME_BAD_SUM;
        else if (pick < 36) kind = FRAME_BAD_END;
        else if (pick < 46) kind = FRAME_GAP;
        else kind = FRAME_GOOD;
        lim = (cur_max_length < 40 || $urandom_range(24) == 0) ? int'(cur_max_length) : 40;
        len = 16'($urandom_range(lim, HeaderLen));
        if (kind == FRAME_BAD_LENGTH) begin
          len = ($urandom_range(1) == 0) ? 16'($urandom_range(HeaderLen - 1))
                                         : 16'($urandom_range(65535, cur_max_length + 1));
        end
        send_frame(len, kind, ($urandom_range(4) == 0));
      end
    end
  endtask

  task automatic test_longest_frame();
    write_reg(CFG_MAX_LENGTH, 11'd1024);
    send_frame(16'd1024, FRAME_GOOD, 1'b0);
    send_frame(16'd1025, FRAME_BAD_LENGTH, 1'b0);
    send_frame(16'd5, FRAME_BAD_END, 1'b0);
  endtask

  initial begin
    reset_deframer();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 74;
    test_reset_registers();
    test_length_errors();
    test_checksum_and_gap();
    test_storage_bound();
    test_random_traffic(170);

    send_idle_pct = 74;
    recv_idle_pct = 31;
    test_random_traffic(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(170);
    test_longest_frame();

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d bytes and %0d result transfers, %0d completed frames.",
             bytes_sent, results_checked, frames_completed);
    $display("Register writes: %0d; mismatches: %0d.", reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
